// ----- design/sensor_command_line_parser_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Sensor command line parser assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_COMMAND_LINE_PARSER_UNIT_MACROS_SVH
`define SENSOR_COMMAND_LINE_PARSER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/scmd_pkg.sv -----
// ----------------------------------------------------------------------------
// Sensor command line parser package
// Command codes, keyword tables, character constants and parse phases.
// ----------------------------------------------------------------------------
`default_nettype none

package scmd_pkg;

  localparam int unsigned PeriodBitsDef = 16;
  localparam int unsigned NumKeys       = 6;

  typedef enum logic [2:0] {
    KIND_SCALE   = 3'd0,
    KIND_PERIOD  = 3'd1,
    KIND_OFF     = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_START   = 3'd4,
    KIND_LOG     = 3'd5,
    KIND_UNKNOWN = 3'd6
  } cmd_kind_e;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } num_phase_e;

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperC  = 8'h43;
  localparam logic [7:0] ChUpperF  = 8'h46;

  // Keyword text, left aligned in 64 bits, first character in the top byte.
  function automatic logic [63:0] key_text(input logic [2:0] k);
    logic [63:0] s;
    case (k)
      3'd0:    s = {"SCALE=", 16'h0000};
      3'd1:    s = {"PERIOD=", 8'h00};
      3'd2:    s = {"OFF", 40'h0};
      3'd3:    s = {"STOP", 32'h0};
      3'd4:    s = {"START", 24'h0};
      3'd5:    s = {"LOG ", 32'h0};
      default: s = 64'h0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] key_char(input logic [2:0] k, input logic [2:0] p);
    logic [63:0] sh;
    sh = key_text(k) << {p, 3'b000};
    return sh[63:56];
  endfunction

  function automatic logic [3:0] key_len(input logic [2:0] k);
    logic [3:0] n;
    case (k)
      3'd0:    n = 4'd6;
      3'd1:    n = 4'd7;
      3'd2:    n = 4'd3;
      3'd3:    n = 4'd4;
      3'd4:    n = 4'd5;
      3'd5:    n = 4'd4;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // OFF, STOP and START must cover the whole line.
  function automatic logic key_exact(input logic [2:0] k);
    return (k == 3'd2) || (k == 3'd3) || (k == 3'd4);
  endfunction

endpackage

`default_nettype wire

// ----- design/sensor_command_line_parser_unit.sv -----
// A newline beat moves from the input register into the result register when it has room.
// Throughput: one byte beat per cycle; the input register drains into the
// parse state every cycle unless a newline must wait for a full result register.
// Reset (rst_ni low, asynchronous): Fahrenheit, period 1, reporting running,
// not halted, line state cleared, both pipeline registers empty.
// ----------------------------------------------------------------------------
// Sensor command line parser unit
// Streams command bytes, recognizes newline-ended command lines on the fly
// and keeps the unit, period, stop and halted flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sensor_command_line_parser_unit_macros.svh"

module sensor_command_line_parser_unit #(
  parameter int unsigned PERIOD_BITS = scmd_pkg::PeriodBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       command_kind_o,
  output logic             argument_error_o,
  output logic             scale_is_celsius_o,
  output logic [15:0]      period_now_o,
  output logic             reports_stopped_now_o,
  output logic             shut_down_o
);
  import scmd_pkg::*;

  // Input register: holds one received byte beat.
  logic       byte_vld_q, byte_vld_d;
  logic [7:0] byte_q;

  // Persistent settings.
  logic                   unit_q, unit_d;
  logic [PERIOD_BITS-1:0] period_q, period_d;
  logic                   stopped_q, stopped_d;
  logic                   halted_q, halted_d;

  // Per-line parse state.
  logic [3:0]             pos_q, pos_d;
  logic [NumKeys-1:0]     alive_q, alive_d;
  logic                   ended_q, ended_d;
  logic [7:0]             letter_q, letter_d;
  num_phase_e             phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [PERIOD_BITS-1:0] value_q, value_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  cmd_kind_e   res_kind_q;
  logic        res_err_q;
  logic        res_unit_q;
  logic [15:0] res_period_q;
  logic        res_stopped_q;
  logic        res_off_q;

  // Handshake and datapath controls.
  logic       in_take;
  logic       out_free;
  logic       makes_result;
  logic       byte_take;
  logic       res_load;
  cmd_kind_e  kind;
  logic       err;
  logic       off;
  logic       is_digit;
  logic       is_space;
  logic [PERIOD_BITS+3:0]  mul;
  logic [PERIOD_BITS+15:0] period_ext;

  // A result slot opens when the current result is empty or is taken now.
  assign out_free     = !out_valid_q || out_ready_i;
  // Only a newline beat on a live block produces a result.
  assign makes_result = !halted_q && (byte_q == ChNewline);
  // Plain bytes always drain; a newline waits for room in the result register.
  assign byte_take    = byte_vld_q && (!makes_result || out_free);
  assign in_ready_o   = !byte_vld_q || byte_take;
  assign in_take      = in_valid_i && in_ready_o;

  always_comb begin
    if (in_take) begin
      byte_vld_d = 1'b1;
    end else if (byte_take) begin
      byte_vld_d = 1'b0;
    end else begin
      byte_vld_d = byte_vld_q;
    end
  end

  // Character classes for the atoi-style period argument.
  assign is_digit = (byte_q >= ChZero) && (byte_q <= ChNine);
  assign is_space = (byte_q == ChSpace) || ((byte_q >= ChTab) && (byte_q <= ChCr));

  // value * 10 + digit as two shifts and adds; four extra bits cover any carry.
  assign mul = ({4'b0000, value_q} << 3) + ({4'b0000, value_q} << 1)
             + {{PERIOD_BITS{1'b0}}, byte_q[3:0]};

  // First live keyword whose full text has been seen wins, lowest index first.
  always_comb begin
    kind = KIND_UNKNOWN;
    for (int k = NumKeys - 1; k >= 0; k--) begin
      if (alive_q[k] && (pos_q >= key_len(3'(k)))) begin
        kind = cmd_kind_e'(3'(k));
      end
    end
  end

  // Main parse step while not halted: one byte beat updates the line state, or a newline
  // closes the line, updates the settings and loads a result.
  always_comb begin
    unit_d    = unit_q;
    period_d  = period_q;
    stopped_d = stopped_q;
    halted_d  = halted_q;
    pos_d     = pos_q;
    alive_d   = alive_q;
    ended_d   = ended_q;
    letter_d  = letter_q;
    phase_d   = phase_q;
    neg_d     = neg_q;
    value_d   = value_q;
    err       = 1'b0;
    off       = 1'b0;
    res_load  = 1'b0;

    if (byte_take && !halted_q) begin
      if (byte_q != ChNewline) begin
        if (!ended_q) begin
          if (byte_q == ChNul) begin
            // A NUL ends the line content; the rest up to newline is dropped.
            ended_d = 1'b1;
          end else begin
            for (int k = 0; k < NumKeys; k++) begin
              if (pos_q < key_len(3'(k))) begin
                if (byte_q != key_char(3'(k), pos_q[2:0])) begin
                  alive_d[k] = 1'b0;
                end
              end else if (key_exact(3'(k))) begin
                alive_d[k] = 1'b0;
              end
            end
            // The byte right after "SCALE=" is the scale letter.
            if (pos_q == 4'd6) begin
              letter_d = byte_q;
            end
            // Everything after "PERIOD=" feeds the number parser.
            if (pos_q >= 4'd7) begin
              if ((phase_q == PH_LEAD) && is_space) begin
                phase_d = PH_LEAD;
              end else if ((phase_q == PH_LEAD) &&
                           ((byte_q == ChPlus) || (byte_q == ChMinus))) begin
                neg_d   = (byte_q == ChMinus);
                phase_d = PH_DIGITS;
              end else if ((phase_q != PH_DONE) && is_digit) begin
                if (mul[PERIOD_BITS+3:PERIOD_BITS] != 4'd0) begin
                  value_d = {PERIOD_BITS{1'b1}};
                end else begin
                  value_d = mul[PERIOD_BITS-1:0];
                end
                phase_d = PH_DIGITS;
              end else begin
                phase_d = PH_DONE;
              end
            end
            if (pos_q != 4'd15) begin
              pos_d = pos_q + 4'd1;
            end
          end
        end
      end else begin
        res_load = 1'b1;
        unique case (kind)
          KIND_SCALE: begin
            if (letter_q == ChUpperC) begin
              unit_d = 1'b1;
            end else if (letter_q == ChUpperF) begin
              unit_d = 1'b0;
            end else begin
              err = 1'b1;
            end
          end
          KIND_PERIOD: begin
            if (!neg_q && (value_q != '0)) begin
              period_d = value_q;
            end else begin
              err = 1'b1;
            end
          end
          KIND_OFF: begin
            halted_d = 1'b1;
            off      = 1'b1;
          end
          KIND_STOP: begin
            stopped_d = 1'b1;
          end
          KIND_START: begin
            stopped_d = 1'b0;
          end
          default: begin
          end
        endcase
        // Start a fresh line.
        pos_d    = 4'd0;
        alive_d  = {NumKeys{1'b1}};
        ended_d  = 1'b0;
        letter_d = ChNul;
        phase_d  = PH_LEAD;
        neg_d    = 1'b0;
        value_d  = '0;
      end
    end
  end

  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // The period is reported in its low 16 bits, zero extended when narrower.
  assign period_ext = {16'h0000, period_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q  <= 1'b0;
      unit_q      <= 1'b0;
      period_q    <= PERIOD_BITS'(1);
      stopped_q   <= 1'b0;
      halted_q    <= 1'b0;
      pos_q       <= 4'd0;
      alive_q     <= {NumKeys{1'b1}};
      ended_q     <= 1'b0;
      letter_q    <= ChNul;
      phase_q     <= PH_LEAD;
      neg_q       <= 1'b0;
      value_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      byte_vld_q  <= byte_vld_d;
      unit_q      <= unit_d;
      period_q    <= period_d;
      stopped_q   <= stopped_d;
      halted_q    <= halted_d;
      pos_q       <= pos_d;
      alive_q     <= alive_d;
      ended_q     <= ended_d;
      letter_q    <= letter_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      value_q     <= value_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= rx_byte_i;
    end
    if (res_load) begin
      res_kind_q    <= kind;
      res_err_q     <= err;
      res_unit_q    <= unit_d;
      res_period_q  <= period_ext[15:0];
      res_stopped_q <= stopped_d;
      res_off_q     <= off;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign command_kind_o        = res_kind_q;
  assign argument_error_o      = res_err_q;
  assign scale_is_celsius_o    = res_unit_q;
  assign period_now_o          = res_period_q;
  assign reports_stopped_now_o = res_stopped_q;
  assign shut_down_o           = res_off_q;

  // The report period is never allowed to become zero.
  `SCMD_ASSERT_NOW(a_period_nonzero, 1'b1, period_q != '0, "report period reached zero")
  // Once halted and drained, no further result beat ever appears.
  `SCMD_ASSERT_NEXT(a_halt_silent, halted_q && !out_valid_q, !out_valid_q, "result after OFF")
  // A shutdown result is always an OFF line.
  `SCMD_ASSERT_NOW(a_off_kind, out_valid_q && res_off_q, res_kind_q == KIND_OFF, "bad shutdown kind")
  // Argument errors belong only to scale and period lines.
  `SCMD_ASSERT_NOW(a_err_kind, out_valid_q && res_err_q, (res_kind_q == KIND_SCALE) || (res_kind_q == KIND_PERIOD), "error on wrong kind")

endmodule

`default_nettype wire
